// ----- sv/fly_camera_pose_update_macros.svh -----
// Assertion macros for the fly camera pose update block.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef FLY_CAMERA_POSE_UPDATE_MACROS_SVH
`define FLY_CAMERA_POSE_UPDATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fcpu_pkg.sv -----
// Shared constants, tables and helper functions for the fly camera block.
// No dependencies.
`default_nettype none
package fcpu_pkg;

    localparam int MUL_AW = 18;
    localparam int MUL_BW = 41;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_AW);

    localparam logic [1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [1:0] CFG_WALK_SPEED  = 2'd1;

    localparam logic [63:0] PITCH_FRAC_Q32  = 64'd1059526179;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sh0000000080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/fly_camera_pose_update.sv -----
// Top level of the fly camera pose update: sequencer, state and output register.
// Depends on fcpu_pkg, fcpu_mul_serial, fcpu_cordic and the assertion macro header.
`default_nettype none
`include "fly_camera_pose_update_macros.svh"
// Each accepted item is one frame tick. The block works on one item at a time; its
// processing time is set by the bit-serial multiplier, which is shared by all eight
// products and takes one multiplier bit per cycle, and by the iterative CORDIC, run
// once for heading and once for elevation. The result waits in an output register,
// and the next item may be accepted while it waits.
module fly_camera_pose_update
    import fcpu_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int POS_FRAC_BITS = 16,
    parameter int TRIG_STEPS    = 16
)(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire [1:0]          cfg_index,
    input  wire [23:0]         cfg_wdata,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire logic signed [15:0] s_mouse_dx,
    input  wire logic signed [15:0] s_mouse_dy,
    input  wire [15:0]         s_time_step,
    input  wire                s_key_ahead,
    input  wire                s_key_back,
    input  wire                s_key_right,
    input  wire                s_key_left,
    input  wire                s_key_rise,
    input  wire                s_key_sink,
    input  wire                s_key_lock,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [31:0] m_aim_x,
    output logic signed [31:0] m_aim_y,
    output logic signed [31:0] m_aim_z,
    output logic               m_lock_toggle
);

    localparam int UP_SHIFT = 32 - ANGLE_BITS;
    localparam int MSHIFT   = 38 - POS_FRAC_BITS;
    localparam logic [63:0] LIMIT_U =
        ((PITCH_FRAC_Q32 << ANGLE_BITS) + 64'h80000000) >> 32;
    localparam logic signed [33:0] LIMIT = $signed(LIMIT_U[33:0]);

    typedef enum logic [3:0] {
        ST_IDLE, ST_YAW, ST_PITCH, ST_HEAD, ST_ELEV, ST_FX, ST_FZ,
        ST_SDT, ST_MX, ST_MY, ST_MZ, ST_FINISH
    } state_t;

    state_t state_reg;

    logic [15:0] sens_reg;
    logic [23:0] speed_reg;
    logic [ANGLE_BITS-1:0] heading_reg;
    logic signed [ANGLE_BITS-1:0] elev_reg;
    logic signed [31:0] place_x_reg, place_y_reg, place_z_reg;

    logic signed [15:0] dy_reg;
    logic [15:0] dt_reg;
    logic ahead_reg, back_reg, right_reg, left_reg, rise_reg, sink_reg, lock_reg;

    logic signed [15:0] ch_reg, sh_reg, ce_reg, se_reg, fx_reg, fz_reg;
    logic [39:0] sdt_reg;

    logic mul_start_reg, mul_start_next;
    logic signed [MUL_AW-1:0] mul_a_reg;
    logic signed [MUL_BW-1:0] mul_b_reg;
    logic cor_start_reg, cor_start_next;
    logic [31:0] cor_angle_reg;

    logic m_valid_reg, lock_out_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg, aim_x_reg, aim_y_reg, aim_z_reg;

    logic mul_done, cor_done;
    logic signed [MUL_PW-1:0] mul_p;
    logic signed [15:0] cor_cos, cor_sin;

    logic signed [MUL_PW-1:0] rnd8, rnd14, rndm;
    logic [ANGLE_BITS-1:0] heading_next;
    logic signed [33:0] elev_diff;
    logic signed [ANGLE_BITS-1:0] elev_next;
    logic signed [15:0] fneg;
    logic signed [17:0] mx, my, mz;
    logic signed [63:0] move;
    logic signed [31:0] place_x_next, place_y_next, place_z_next;

    fcpu_mul_serial u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    fcpu_cordic #(.TRIG_STEPS(TRIG_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start_reg),
        .angle   (cor_angle_reg),
        .done    (cor_done),
        .cos_q14 (cor_cos),
        .sin_q14 (cor_sin)
    );

    function automatic logic signed [17:0] key_term(input logic pos, input logic neg,
                                                    input logic signed [15:0] v);
        logic signed [17:0] r;
        if (pos && !neg) begin
            r = 18'(v);
        end else if (neg && !pos) begin
            r = -18'(v);
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] aim_of(input logic signed [31:0] pos,
                                                  input logic signed [15:0] f);
        logic signed [63:0] off;
        off = ((64'(f) <<< POS_FRAC_BITS) + 64'sd8192) >>> 14;
        return sat32(64'(pos) + off);
    endfunction

    assign rnd8  = (mul_p + MUL_PW'(128)) >>> 8;
    assign rnd14 = (mul_p + MUL_PW'(8192)) >>> 14;
    assign rndm  = (mul_p + (MUL_PW'(1) <<< (MSHIFT - 1))) >>> MSHIFT;
    assign move  = 64'(rndm);
    assign fneg  = -rnd14[15:0];

    assign heading_next = heading_reg - rnd8[ANGLE_BITS-1:0];
    assign elev_diff    = 34'(elev_reg) - rnd8[33:0];

    always_comb begin
        if (elev_diff > LIMIT) begin
            elev_next = LIMIT[ANGLE_BITS-1:0];
        end else if (elev_diff < -LIMIT) begin
            elev_next = ANGLE_BITS'(-LIMIT);
        end else begin
            elev_next = elev_diff[ANGLE_BITS-1:0];
        end
    end

    assign mx = key_term(ahead_reg, back_reg, fx_reg) + key_term(right_reg, left_reg, ch_reg);
    assign my = key_term(ahead_reg, back_reg, se_reg) + key_term(rise_reg, sink_reg, ONE_Q14);
    assign mz = key_term(ahead_reg, back_reg, fz_reg) - key_term(right_reg, left_reg, sh_reg);

    assign place_x_next = sat32(64'(place_x_reg) + move);
    assign place_y_next = sat32(64'(place_y_reg) + move);
    assign place_z_next = sat32(64'(place_z_reg) + move);

    assign mul_start_next = ((state_reg == ST_IDLE) && s_valid)
                         || ((state_reg == ST_ELEV) && cor_done)
                         || (mul_done && ((state_reg == ST_YAW) || (state_reg == ST_FX)
                                       || (state_reg == ST_FZ) || (state_reg == ST_SDT)
                                       || (state_reg == ST_MX) || (state_reg == ST_MY)));
    assign cor_start_next = ((state_reg == ST_PITCH) && mul_done)
                         || ((state_reg == ST_HEAD) && cor_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            sens_reg      <= 16'd256;
            speed_reg     <= 24'd256;
            heading_reg   <= '0;
            elev_reg      <= '0;
            place_x_reg   <= '0;
            place_y_reg   <= '0;
            place_z_reg   <= '0;
        end else begin
            mul_start_reg <= mul_start_next;
            cor_start_reg <= cor_start_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SENSITIVITY: sens_reg  <= cfg_wdata[15:0];
                    CFG_WALK_SPEED:  speed_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if ((state_reg == ST_FINISH) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dy_reg        <= s_mouse_dy;
                        dt_reg        <= s_time_step;
                        ahead_reg     <= s_key_ahead;
                        back_reg      <= s_key_back;
                        right_reg     <= s_key_right;
                        left_reg      <= s_key_left;
                        rise_reg      <= s_key_rise;
                        sink_reg      <= s_key_sink;
                        lock_reg      <= s_key_lock;
                        mul_a_reg     <= MUL_AW'(s_mouse_dx);
                        mul_b_reg     <= MUL_BW'(sens_reg);
                        state_reg     <= ST_YAW;
                    end
                end
                ST_YAW: begin
                    if (mul_done) begin
                        heading_reg   <= heading_next;
                        mul_a_reg     <= MUL_AW'(dy_reg);
                        mul_b_reg     <= MUL_BW'(sens_reg);
                        state_reg     <= ST_PITCH;
                    end
                end
                ST_PITCH: begin
                    if (mul_done) begin
                        elev_reg      <= elev_next;
                        cor_angle_reg <= 32'(heading_reg) << UP_SHIFT;
                        state_reg     <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if (cor_done) begin
                        ch_reg        <= cor_cos;
                        sh_reg        <= cor_sin;
                        cor_angle_reg <= 32'(elev_reg) << UP_SHIFT;
                        state_reg     <= ST_ELEV;
                    end
                end
                ST_ELEV: begin
                    if (cor_done) begin
                        ce_reg        <= cor_cos;
                        se_reg        <= cor_sin;
                        mul_a_reg     <= MUL_AW'(sh_reg);
                        mul_b_reg     <= MUL_BW'(cor_cos);
                        state_reg     <= ST_FX;
                    end
                end
                ST_FX: begin
                    if (mul_done) begin
                        fx_reg        <= fneg;
                        mul_a_reg     <= MUL_AW'(ch_reg);
                        mul_b_reg     <= MUL_BW'(ce_reg);
                        state_reg     <= ST_FZ;
                    end
                end
                ST_FZ: begin
                    if (mul_done) begin
                        fz_reg        <= fneg;
                        mul_a_reg     <= $signed(MUL_AW'(dt_reg));
                        mul_b_reg     <= $signed(MUL_BW'(speed_reg));
                        state_reg     <= ST_SDT;
                    end
                end
                ST_SDT: begin
                    if (mul_done) begin
                        sdt_reg       <= mul_p[39:0];
                        mul_a_reg     <= mx;
                        mul_b_reg     <= $signed(MUL_BW'(mul_p[39:0]));
                        state_reg     <= ST_MX;
                    end
                end
                ST_MX: begin
                    if (mul_done) begin
                        place_x_reg   <= place_x_next;
                        mul_a_reg     <= my;
                        mul_b_reg     <= $signed(MUL_BW'(sdt_reg));
                        state_reg     <= ST_MY;
                    end
                end
                ST_MY: begin
                    if (mul_done) begin
                        place_y_reg   <= place_y_next;
                        mul_a_reg     <= mz;
                        mul_b_reg     <= $signed(MUL_BW'(sdt_reg));
                        state_reg     <= ST_MZ;
                    end
                end
                ST_MZ: begin
                    if (mul_done) begin
                        place_z_reg <= place_z_next;
                        state_reg   <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        pos_x_reg    <= place_x_reg;
                        pos_y_reg    <= place_y_reg;
                        pos_z_reg    <= place_z_reg;
                        aim_x_reg    <= aim_of(place_x_reg, fx_reg);
                        aim_y_reg    <= aim_of(place_y_reg, se_reg);
                        aim_z_reg    <= aim_of(place_z_reg, fz_reg);
                        lock_out_reg <= lock_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pos_x       = pos_x_reg;
    assign m_pos_y       = pos_y_reg;
    assign m_pos_z       = pos_z_reg;
    assign m_aim_x       = aim_x_reg;
    assign m_aim_y       = aim_y_reg;
    assign m_aim_z       = aim_z_reg;
    assign m_lock_toggle = lock_out_reg;

    `FCPU_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `FCPU_ASSERT_NOW(a_elev_in_range, 1'b1, (34'(elev_reg) <= LIMIT) && (34'(elev_reg) >= -LIMIT), "elevation out of range")
    `FCPU_ASSERT_NOW(a_result_from_finish, $rose(m_valid_reg), $past(state_reg == ST_FINISH), "result without finish")

endmodule
`default_nettype wire

// ----- sv/fcpu_mul_serial.sv -----
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on fcpu_pkg for operand and product widths.
`default_nettype none
module fcpu_mul_serial
    import fcpu_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire logic signed [MUL_AW-1:0] a,
    input  wire logic signed [MUL_BW-1:0] b,
    output logic                      done,
    output logic signed [MUL_PW-1:0]  p
);

    logic signed [MUL_PW-1:0] acc_reg;
    logic signed [MUL_PW-1:0] mc_reg;
    logic [MUL_AW-1:0]        bits_reg;
    logic [MUL_CW-1:0]        cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [MUL_PW-1:0] addend;

    assign addend = bits_reg[0] ? mc_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            acc_reg  <= '0;
            mc_reg   <= MUL_PW'(b);
            bits_reg <= a;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            // The top bit of a two's complement multiplier has negative weight.
            if (cnt_reg == MUL_CW'(MUL_AW - 1)) begin
                acc_reg  <= acc_reg - addend;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                acc_reg  <= acc_reg + addend;
                done_reg <= 1'b0;
            end
            mc_reg   <= mc_reg <<< 1;
            bits_reg <= bits_reg >> 1;
            cnt_reg  <= cnt_reg + 1'b1;
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

// ----- sv/fcpu_cordic.sv -----
// Iterative rotation-mode CORDIC giving Q2.14 cosine and sine of a 32-bit binary angle.
// Depends on fcpu_pkg for the arctangent table and gain constant.
`default_nettype none
module fcpu_cordic
    import fcpu_pkg::*;
#(
    parameter int TRIG_STEPS = 16
)(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  wire [31:0]         angle,
    output logic               done,
    output logic signed [15:0] cos_q14,
    output logic signed [15:0] sin_q14
);

    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [1:0]         q_reg;
    logic [4:0]         i_reg;
    logic               busy_reg, fin_reg, done_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [33:0] xs, ys, xr, yr;
    logic signed [32:0] at;
    logic signed [15:0] cr, sr;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = $signed({1'b0, atan_turn(i_reg)});
    assign xr = (x_reg + 34'sd32768) >>> 16;
    assign yr = (y_reg + 34'sd32768) >>> 16;

    always_comb begin
        if (xr > 34'sd16384) begin
            cr = ONE_Q14;
        end else if (xr < -34'sd16384) begin
            cr = -ONE_Q14;
        end else begin
            cr = xr[15:0];
        end
        if (yr > 34'sd16384) begin
            sr = ONE_Q14;
        end else if (yr < -34'sd16384) begin
            sr = -ONE_Q14;
        end else begin
            sr = yr[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= $signed({3'b000, angle[29:0]});
            q_reg    <= angle[31:30];
            i_reg    <= '0;
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            i_reg    <= i_reg + 1'b1;
            done_reg <= 1'b0;
            if (i_reg == 5'(TRIG_STEPS - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
            unique case (q_reg)
                2'd0: begin cos_reg <= cr;  sin_reg <= sr;  end
                2'd1: begin cos_reg <= -sr; sin_reg <= cr;  end
                2'd2: begin cos_reg <= -cr; sin_reg <= -sr; end
                2'd3: begin cos_reg <= sr;  sin_reg <= -cr; end
                default: begin cos_reg <= cr; sin_reg <= sr; end
            endcase
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done    = done_reg;
    assign cos_q14 = cos_reg;
    assign sin_q14 = sin_reg;

endmodule
`default_nettype wire

// ----- verif/fly_camera_pose_update_test.sv -----
// Self-checking testbench for fly_camera_pose_update: frame ticks go in, poses come out.
// It predicts each pose from the configured sensitivity, speed and its own camera state.
// Depends on fcpu_pkg and the fly_camera_pose_update RTL.
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        dt;
    logic               ahead, back, right, left, rise, sink, lock;
} tick_t;

typedef struct {
    logic signed [31:0] px, py, pz, ax, ay, az;
    logic               lock;
} pose_t;

class pose_scoreboard;
    longint sens, speed, elev, px, py, pz;
    logic [15:0] heading;
    pose_t poses_due[$];
    int mismatches;
    int poses_seen;
    longint arc_q32[16] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D};

    function new();
        sens = 256;
        speed = 256;
        heading = 0;
        elev = 0;
        px = 0;
        py = 0;
        pz = 0;
        mismatches = 0;
        poses_seen = 0;
    endfunction

    function longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat(longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void sin_cos(logic [31:0] a, output longint c, output longint s);
        longint x, y, z, xs, ys, cr, sr;
        x = 652032874;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= arc_q32[i];
            end else begin
                x += ys; y -= xs; z += arc_q32[i];
            end
        end
        cr = clip(round_shift(x, 16), -16384, 16384);
        sr = clip(round_shift(y, 16), -16384, 16384);
        case (a[31:30])
            2'd0: begin c = cr;  s = sr;  end
            2'd1: begin c = -sr; s = cr;  end
            2'd2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    function void set_register(logic [1:0] idx, logic [23:0] data);
        if (idx == fcpu_pkg::CFG_SENSITIVITY) begin
            sens = longint'(data[15:0]);
        end else if (idx == fcpu_pkg::CFG_WALK_SPEED) begin
            speed = longint'(data);
        end
    endfunction

    function void note_tick(tick_t t);
        longint dyaw, dpitch, ch, sh, ce, se, fx, fy, fz, mx, my, mz, sdt;
        longint fwd, strafe, lift;
        logic [31:0] ang;
        pose_t p;
        dyaw = round_shift(longint'(t.dx) * sens, 8);
        dpitch = round_shift(longint'(t.dy) * sens, 8);
        fwd = longint'(t.ahead) - longint'(t.back);
        strafe = longint'(t.right) - longint'(t.left);
        lift = longint'(t.rise) - longint'(t.sink);
        heading = heading - dyaw[15:0];
        elev = clip(elev - dpitch, -16167, 16167);
        sin_cos({heading, 16'h0}, ch, sh);
        ang = 32'(elev * 65536);
        sin_cos(ang, ce, se);
        fx = -round_shift(sh * ce, 14);
        fy = se;
        fz = -round_shift(ch * ce, 14);
        mx = fwd * fx + strafe * ch;
        my = fwd * fy + lift * 16384;
        mz = fwd * fz - strafe * sh;
        sdt = speed * longint'(t.dt);
        px = sat(px + round_shift(mx * sdt, 22));
        py = sat(py + round_shift(my * sdt, 22));
        pz = sat(pz + round_shift(mz * sdt, 22));
        p.px = 32'(px);
        p.py = 32'(py);
        p.pz = 32'(pz);
        p.ax = 32'(sat(px + round_shift(fx * 65536, 14)));
        p.ay = 32'(sat(py + round_shift(fy * 65536, 14)));
        p.az = 32'(sat(pz + round_shift(fz * 65536, 14)));
        p.lock = t.lock;
        poses_due.push_back(p);
    endfunction

    task report(string what, longint got, longint want);
        $display("pose %0d: %s got %0d, expected %0d", poses_seen, what, got, want);
        mismatches++;
    endtask

    task check_pose(pose_t g);
        pose_t w;
        poses_seen++;
        if (poses_due.size() == 0) begin
            report("unexpected pose, pos_x", g.px, 0);
        end else begin
            w = poses_due.pop_front();
            if (g.px !== w.px) report("pos_x", g.px, w.px);
            if (g.py !== w.py) report("pos_y", g.py, w.py);
            if (g.pz !== w.pz) report("pos_z", g.pz, w.pz);
            if (g.ax !== w.ax) report("aim_x", g.ax, w.ax);
            if (g.ay !== w.ay) report("aim_y", g.ay, w.ay);
            if (g.az !== w.az) report("aim_z", g.az, w.az);
            if (g.lock !== w.lock) report("lock_toggle", g.lock, w.lock);
        end
    endtask
endclass

module fly_camera_pose_update_test;
    import fcpu_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_mouse_dx = '0, s_mouse_dy = '0;
    logic [15:0] s_time_step = '0;
    logic s_key_ahead = 0, s_key_back = 0, s_key_right = 0, s_key_left = 0;
    logic s_key_rise = 0, s_key_sink = 0, s_key_lock = 0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z, m_aim_x, m_aim_y, m_aim_z;
    logic m_lock_toggle;

    pose_scoreboard sb = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int ticks_sent = 0;

    fly_camera_pose_update dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        tick_t t;
        pose_t p;
        if (aresetn && s_valid && s_ready) begin
            t.dx = s_mouse_dx; t.dy = s_mouse_dy; t.dt = s_time_step;
            t.ahead = s_key_ahead; t.back = s_key_back; t.right = s_key_right;
            t.left = s_key_left; t.rise = s_key_rise; t.sink = s_key_sink;
            t.lock = s_key_lock;
            sb.note_tick(t);
        end
        if (aresetn && m_valid && m_ready) begin
            p.px = m_pos_x; p.py = m_pos_y; p.pz = m_pos_z;
            p.ax = m_aim_x; p.ay = m_aim_y; p.az = m_aim_z;
            p.lock = m_lock_toggle;
            sb.check_pose(p);
        end
    end

    // The receiver switches between always ready, random stalls and long stalls.
    always @(posedge aclk) begin
        int mode;
        mode = int'(($time / 6000) % 3);
        case (mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 24) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("fly_camera_pose_update: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(tick_t t);
        int gap;
        s_valid <= 1'b1;
        s_mouse_dx <= t.dx; s_mouse_dy <= t.dy; s_time_step <= t.dt;
        s_key_ahead <= t.ahead; s_key_back <= t.back; s_key_right <= t.right;
        s_key_left <= t.left; s_key_rise <= t.rise; s_key_sink <= t.sink;
        s_key_lock <= t.lock;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic write_register(logic [1:0] idx, logic [23:0] data);
        s_valid <= 1'b0;
        while (sb.poses_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_register(idx, data);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic tick_t make_tick(logic signed [15:0] dx, logic signed [15:0] dy,
                                        logic [15:0] dt, logic [6:0] keys);
        tick_t t;
        t.dx = dx; t.dy = dy; t.dt = dt;
        {t.ahead, t.back, t.right, t.left, t.rise, t.sink, t.lock} = keys;
        return t;
    endfunction

    function automatic tick_t random_tick();
        logic signed [15:0] dx, dy;
        logic [15:0] dt;
        if ($urandom_range(0, 3) == 0) begin
            dx = 16'($urandom);
            dy = 16'($urandom);
        end else begin
            dx = $signed(16'($urandom_range(0, 800))) - 16'sd400;
            dy = $signed(16'($urandom_range(0, 800))) - 16'sd400;
        end
        dt = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        return make_tick(dx, dy, dt, 7'($urandom));
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Key pairs held together cancel; pitch runs into both clamps.
        send_tick(make_tick(0, 0, 0, 7'b0000000));
        send_tick(make_tick(16'sh7FFF, 0, 100, 7'b1000000));
        send_tick(make_tick(-16'sh8000, 0, 100, 7'b0100000));
        send_tick(make_tick(0, 16'sh7FFF, 65535, 7'b1000000));
        send_tick(make_tick(0, -16'sh8000, 65535, 7'b0100000));
        send_tick(make_tick(0, 0, 65535, 7'b1100000));
        send_tick(make_tick(0, 0, 65535, 7'b0010000));
        send_tick(make_tick(0, 0, 65535, 7'b0001000));
        send_tick(make_tick(0, 0, 65535, 7'b0011000));
        send_tick(make_tick(0, 0, 65535, 7'b0000100));
        send_tick(make_tick(0, 0, 65535, 7'b0000010));
        send_tick(make_tick(0, 0, 65535, 7'b0000110));
        send_tick(make_tick(0, 0, 0, 7'b0000001));
        send_tick(make_tick(1, -1, 1, 7'b1111111));

        // Full sensitivity wraps the heading; full speed drives position into saturation.
        write_register(CFG_SENSITIVITY, 24'hFFFF);
        write_register(CFG_WALK_SPEED, 24'hFFFFFF);
        write_register(CFG_SPARE, 24'h000001);
        send_tick(make_tick(16'sh7FFF, 0, 65535, 7'b1000100));
        send_tick(make_tick(16'sh4000, 0, 65535, 7'b1010100));
        send_tick(make_tick(-16'sh8000, 16'sh7FFF, 65535, 7'b0101010));
        send_tick(make_tick(0, 0, 65535, 7'b0101010));
        send_tick(make_tick(0, 0, 65535, 7'b0101011));
        write_register(CFG_SENSITIVITY, 24'h0);
        write_register(CFG_WALK_SPEED, 24'h0);
        send_tick(make_tick(16'sh7FFF, -16'sh8000, 65535, 7'b1010100));
        send_tick(make_tick(-16'sh8000, 16'sh7FFF, 65535, 7'b0101010));

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_SENSITIVITY, 24'd256);
                    write_register(CFG_WALK_SPEED, 24'd256);
                end
                1: begin
                    write_register(CFG_SENSITIVITY, 24'hFFFF);
                    write_register(CFG_WALK_SPEED, 24'hFFFFFF);
                end
                2: begin
                    write_register(CFG_SENSITIVITY, 24'd0);
                    write_register(CFG_WALK_SPEED, 24'd0);
                end
                default: begin
                    write_register(CFG_SENSITIVITY, 24'($urandom_range(0, 65535)));
                    write_register(CFG_WALK_SPEED, 24'($urandom));
                end
            endcase
            for (int n = 0; n < 180; n++) send_tick(random_tick());
        end

        s_valid <= 1'b0;
        while (sb.poses_due.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        $display("%0d ticks sent, %0d poses checked over several sensitivity and speed settings",
                 ticks_sent, sb.poses_seen);
        $display("covered key pairs, pitch clamping, heading wrap and position saturation");
        if (sb.mismatches == 0 && sb.poses_due.size() == 0) begin
            $display("fly_camera_pose_update: match");
        end else begin
            $display("fly_camera_pose_update: mismatch");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/fcpu_pkg.sv
sv/fcpu_mul_serial.sv
sv/fcpu_cordic.sv
sv/fly_camera_pose_update.sv
verif/fly_camera_pose_update_test.sv
